>>> src/kpe_pkg.sv
// kpe_pkg: shared types and constants of the key press event detector
// no dependencies; used by kpe_cfg_regs, kpe_core and key_press_event_fsm_top
`timescale 1ns / 1ps

package kpe_pkg;

  localparam int unsigned KeyWidth   = 8;
  localparam int unsigned CfgWidth   = 16;
  localparam int unsigned EventWidth = 3;
  localparam int unsigned CfgIdxWidth = 2;

  localparam logic [KeyWidth-1:0] ComboBit = 8'h80;

  localparam logic [CfgWidth-1:0] LongTicksReset   = 16'd100;
  localparam logic [CfgWidth-1:0] WaitTicksReset   = 16'd50;
  localparam logic [CfgWidth-1:0] RepeatTicksReset = 16'd50;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgLongTicks   = 2'd0,
    CfgWaitTicks   = 2'd1,
    CfgRepeatTicks = 2'd2
  } cfg_idx_e;

  typedef enum logic [5:0] {
    StIdle    = 6'b000001,
    StPress   = 6'b000010,
    StLong    = 6'b000100,
    StWait    = 6'b001000,
    StRepeat  = 6'b010000,
    StRelease = 6'b100000
  } step_e;

  typedef enum logic [1:0] {
    KindNone   = 2'd0,
    KindDown   = 2'd1,
    KindLong   = 2'd2,
    KindRepeat = 2'd3
  } kind_e;

  typedef enum logic [EventWidth-1:0] {
    EvNone     = 3'd0,
    EvDown     = 3'd1,
    EvLong     = 3'd2,
    EvRepeat   = 3'd3,
    EvDownUp   = 3'd4,
    EvLongUp   = 3'd5,
    EvRepeatUp = 3'd6
  } event_e;

  typedef struct packed {
    logic [CfgWidth-1:0] long_ticks;
    logic [CfgWidth-1:0] wait_ticks;
    logic [CfgWidth-1:0] repeat_ticks;
  } cfg_t;

endpackage

>>> src/kpe_cfg_regs.sv
// kpe_cfg_regs: timing limit registers written over the configuration channel
// depends on kpe_pkg
`timescale 1ns / 1ps

module kpe_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic [kpe_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  logic [kpe_pkg::CfgWidth-1:0]       cfg_data_i,
  output kpe_pkg::cfg_t                      cfg_o
);

  kpe_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (kpe_pkg::cfg_idx_e'(cfg_index_i))
        kpe_pkg::CfgLongTicks:   cfg_d.long_ticks   = cfg_data_i;
        kpe_pkg::CfgWaitTicks:   cfg_d.wait_ticks   = cfg_data_i;
        kpe_pkg::CfgRepeatTicks: cfg_d.repeat_ticks = cfg_data_i;
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_ticks   <= kpe_pkg::LongTicksReset;
      cfg_q.wait_ticks   <= kpe_pkg::WaitTicksReset;
      cfg_q.repeat_ticks <= kpe_pkg::RepeatTicksReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/kpe_core.sv
// kpe_core: step state machine, hold counter and event decode for one scan tick
// depends on kpe_pkg
`timescale 1ns / 1ps

module kpe_core #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              fire_i,
  input  logic [kpe_pkg::KeyWidth-1:0]      key_i,
  input  kpe_pkg::cfg_t                     cfg_i,
  output logic [kpe_pkg::EventWidth-1:0]    event_o,
  output logic [kpe_pkg::KeyWidth-1:0]      key_o
);

  localparam int unsigned CmpWidth =
      (COUNT_WIDTH > kpe_pkg::CfgWidth) ? COUNT_WIDTH : kpe_pkg::CfgWidth;

  kpe_pkg::step_e                 step_q, step_d;
  kpe_pkg::kind_e                 kind_q, kind_d;
  logic [COUNT_WIDTH-1:0]         count_q, count_d, count_inc;
  logic [kpe_pkg::KeyWidth-1:0]   held_q, held_d;
  logic                           same_key;
  logic                           long_hit, wait_hit, repeat_hit;
  kpe_pkg::event_e                ev;

  // saturating hold count
  assign count_inc = (count_q == {COUNT_WIDTH{1'b1}}) ? count_q : count_q + 1'b1;
  assign same_key  = (held_q == key_i);

  assign long_hit   = CmpWidth'(count_inc) > CmpWidth'(cfg_i.long_ticks);
  assign wait_hit   = CmpWidth'(count_inc) > CmpWidth'(cfg_i.wait_ticks);
  assign repeat_hit = CmpWidth'(count_inc) > CmpWidth'(cfg_i.repeat_ticks);

  always_comb begin
    step_d  = step_q;
    kind_d  = kind_q;
    count_d = count_q;
    held_d  = held_q;
    ev      = kpe_pkg::EvNone;
    key_o   = key_i;
    unique case (step_q)
      kpe_pkg::StIdle: begin
        if (key_i != '0) begin
          count_d = '0;
          held_d  = key_i;
          step_d  = kpe_pkg::StPress;
        end
      end
      kpe_pkg::StPress: begin
        if (same_key) begin
          ev     = kpe_pkg::EvDown;
          kind_d = kpe_pkg::KindDown;
          step_d = kpe_pkg::StLong;
        end else begin
          step_d = kpe_pkg::StIdle;
        end
      end
      kpe_pkg::StLong: begin
        if (same_key) begin
          count_d = count_inc;
          if (long_hit) begin
            count_d = '0;
            ev      = kpe_pkg::EvLong;
            kind_d  = kpe_pkg::KindLong;
            step_d  = kpe_pkg::StWait;
          end
        end else begin
          step_d = kpe_pkg::StRelease;
        end
      end
      kpe_pkg::StWait: begin
        // timeout wins over a key change on the same tick
        count_d = count_inc;
        if (wait_hit) begin
          count_d = '0;
          step_d  = kpe_pkg::StRepeat;
        end else if (!same_key) begin
          step_d = kpe_pkg::StRelease;
        end
      end
      kpe_pkg::StRepeat: begin
        if (same_key) begin
          count_d = count_inc;
          if (repeat_hit) begin
            count_d = '0;
            ev      = kpe_pkg::EvRepeat;
            kind_d  = kpe_pkg::KindRepeat;
          end
        end else begin
          step_d = kpe_pkg::StRelease;
        end
      end
      kpe_pkg::StRelease: begin
        step_d = kpe_pkg::StIdle;
        // plain key turning into a combination key: no release report
        if (!((held_q & kpe_pkg::ComboBit) == '0 && (key_i & kpe_pkg::ComboBit) != '0)) begin
          key_o = held_q;
          unique case (kind_q)
            kpe_pkg::KindDown:   ev = kpe_pkg::EvDownUp;
            kpe_pkg::KindLong:   ev = kpe_pkg::EvLongUp;
            kpe_pkg::KindRepeat: ev = kpe_pkg::EvRepeatUp;
            default:             ev = kpe_pkg::EvNone;
          endcase
        end
      end
      default: begin
        step_d = kpe_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= kpe_pkg::StIdle;
      kind_q  <= kpe_pkg::KindNone;
      count_q <= '0;
      held_q  <= '0;
    end else if (fire_i) begin
      step_q  <= step_d;
      kind_q  <= kind_d;
      count_q <= count_d;
      held_q  <= held_d;
    end
  end

  assign event_o = ev;

endmodule

>>> src/key_press_event_fsm_top.sv
// key_press_event_fsm_top: key press event detector with input and result registers
// depends on kpe_pkg, kpe_cfg_regs, kpe_core
`timescale 1ns / 1ps

// Key press event detector.
// s_axis carries one key sample per scan tick (tdata[7:0] = key_code, 0 = no key,
// bit 7 = combination key). m_axis returns exactly one result per sample:
// tdata[2:0] = event_res, tdata[10:3] = key_out, upper bits zero.
// The cfg channel writes the timing limits: index 0 long_ticks, 1 wait_ticks,
// 2 repeat_ticks; other indexes are ignored. cfg_ready_o is always high;
// write only while no sample is in flight.
// Throughput: one sample per cycle while m_axis does not stall. A request passes
// the input register, then the state machine into the result register, before
// m_axis valid rises.
// Reset clears the valid bits of both registers, the step state, hold count, held
// key and last kind, and loads the limits with 100, 50 and 50.
// When m_axis stalls the result register holds, the input register takes one
// more request, and s_axis_tready then drops until the result is taken.

module key_press_event_fsm_top #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // [7:0] key_code
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [15:0]                     m_axis_tdata,   // [2:0] event_res, [10:3] key_out
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [kpe_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  logic [kpe_pkg::CfgWidth-1:0]    cfg_data_i
);

  kpe_pkg::cfg_t                   cfg;
  logic                            in_valid_q;
  logic [kpe_pkg::KeyWidth-1:0]    in_key_q;
  logic                            out_valid_q;
  logic [kpe_pkg::EventWidth-1:0]  out_event_q, core_event;
  logic [kpe_pkg::KeyWidth-1:0]    out_key_q, core_key;
  logic                            advance;

  assign cfg_ready_o = 1'b1;

  kpe_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // a sample moves on when the result register is free or being emptied
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_key_q <= s_axis_tdata;
    end
  end

  kpe_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (advance),
    .key_i   (in_key_q),
    .cfg_i   (cfg),
    .event_o (core_event),
    .key_o   (core_key)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_event_q <= core_event;
      out_key_q   <= core_key;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_key_q, out_event_q};

endmodule

>>> src/kpe_checker.sv
// kpe_checker: port-level assertions for key_press_event_fsm_top
// bound to the top level; no package dependencies
`timescale 1ns / 1ps

module kpe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        cfg_ready_o
);

  // a request reaches the output via both registers if the sink is ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("accepted sample did not reach the output");

  // event code 7 is never produced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[2:0] != 3'd7))
    else $error("invalid event code");

  // upper padding bits stay zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[15:11] == 5'd0))
    else $error("padding bits set");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("configuration channel not ready");

endmodule

bind key_press_event_fsm_top kpe_checker u_kpe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_ready_o   (cfg_ready_o)
);
